/* hw/rtl/pms_pkg.sv */
// Shared types and codes for the partitioned multi-stack block.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

  localparam int WORD_W = 32;

  // Operation carried in the low bits of the input tuser.
  typedef enum logic [1:0] {
    ACT_PUSH      = 2'd0,
    ACT_POP       = 2'd1,
    ACT_SHIFT_UP  = 2'd2,
    ACT_SHIFT_DN  = 2'd3
  } action_t;

  // Completion status returned with every result.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NO_SHIFT = 3'd3,
    ST_NO_SPACE = 3'd4
  } status_t;

endpackage

`default_nettype wire

/* hw/rtl/partitioned_multi_stack.sv */
// Top level of the partitioned multi-stack: sequencer, region pointers and shared word memory.
// Depends on pms_pkg for the operation and status codes.
`timescale 1ns / 1ps
`default_nettype none

// Several stacks share one word memory of DEPTH entries, each stack owning an
// adjacent region. Every input transaction on the s_axis side carries an
// operation and a stack number in tuser and a push word in tdata; every one
// produces exactly one result transaction on the m_axis side, carrying the
// popped word in tdata and a status code in tuser.
// Timing: the block works on one transaction at a time. A push, or any
// operation that fails, is decided in the execute state and loaded into the
// output register, if it is free, as the block returns to idle, where the next
// transaction can be accepted. A pop adds a state for the synchronous memory
// read. A successful shift moves its words one at a time, each word one read
// followed by one write through the single memory port pair, and its result
// leaves from idle once the last word is written.
// The result sits in an output register, so a new transaction is taken while
// an earlier result still waits; when the receiver stalls and the next result
// is ready, the sequencer holds it until the output register frees up, and
// the input side stays not ready meanwhile.
// Reset (synchronous, active high) empties all stacks and splits the memory
// into equal regions; the memory contents themselves are not cleared.
module partitioned_multi_stack
  import pms_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int STACKS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  wire logic [3:0]  s_axis_tuser,   // [1:0] action, [3:2] stack_index
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] pop_value
  output logic [2:0]       m_axis_tuser    // [2:0] status
);

  // Pointer width holds DEPTH itself; memory address width covers DEPTH-1.
  localparam int AW = $clog2(DEPTH + 1);
  localparam int MW = $clog2(DEPTH);
  // Width of a stack number inside the block.
  localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam int XW = (SW > 2) ? SW : 2;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EXEC    = 5'b00010,
    S_POP_RD  = 5'b00100,
    S_MOVE_RD = 5'b01000,
    S_MOVE_WR = 5'b10000
  } state_t;

  state_t state;

  // Accepted transaction.
  action_t            item_action;
  logic [1:0]         item_stack;
  logic [WORD_W-1:0]  item_value;

  // Region bounds and fill pointers, one lane per stack.
  logic [AW-1:0] region_start [STACKS];
  logic [AW-1:0] fill_point   [STACKS];
  logic [AW-1:0] limit        [STACKS];
  logic [STACKS-1:0] lane_full;

  // Shared word memory.
  logic [WORD_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [MW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [MW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // Block move cursor.
  logic [AW-1:0] ptr;
  logic [AW-1:0] stop;
  logic          move_up;

  // Result waiting for the output register.
  status_t           res_status;
  logic              res_pending;

  // Decision for the transaction in hand.
  logic [XW-1:0] s_wide;
  logic          s_valid;
  logic [SW-1:0] s_sel;
  logic          s_last;
  logic [AW-1:0] fill_s;
  logic [AW-1:0] start_s;
  logic [AW-1:0] limit_s;
  logic          full_s;
  logic [SW-1:0] jr;
  logic          jr_found;
  logic [SW-1:0] jl;
  logic          jl_found;

  status_t           dec_status;
  logic              dec_push;
  logic              dec_pop;
  logic              dec_move;
  logic              dec_up;
  logic [AW-1:0]     dec_ptr;
  logic [AW-1:0]     dec_stop;
  logic [STACKS-1:0] inc_mask;
  logic [STACKS-1:0] dec_mask;

  logic          out_free;
  logic          out_load;
  logic [WORD_W-1:0] out_value;
  status_t       out_status;
  logic [AW-1:0] ptr_step;

  // Each lane's upper limit is the next region's base, or the memory end.
  for (genvar k = 0; k < STACKS; k++) begin : g_lane
    if (k == STACKS - 1) begin : g_last
      assign limit[k] = AW'(DEPTH);
    end else begin : g_mid
      assign limit[k] = region_start[k + 1];
    end
    assign lane_full[k] = (fill_point[k] >= limit[k]);
  end

  assign s_wide  = XW'(item_stack);
  assign s_valid = ({1'b0, s_wide} < (XW + 1)'(STACKS));
  assign s_sel   = s_wide[SW-1:0];
  assign s_last  = (s_sel == SW'(STACKS - 1));
  assign fill_s  = fill_point[s_sel];
  assign start_s = region_start[s_sel];
  assign limit_s = limit[s_sel];
  assign full_s  = lane_full[s_sel];

  // Nearest stack above and below the addressed one that still has room.
  always_comb begin
    jr = '0;
    jr_found = 1'b0;
    for (int k = STACKS - 1; k >= 0; k--) begin
      if ((SW'(k) > s_sel) && !lane_full[k]) begin
        jr = SW'(k);
        jr_found = 1'b1;
      end
    end
    jl = '0;
    jl_found = 1'b0;
    for (int k = 0; k < STACKS; k++) begin
      if ((SW'(k) < s_sel) && !lane_full[k]) begin
        jl = SW'(k);
        jl_found = 1'b1;
      end
    end
  end

  always_comb begin
    dec_status = ST_OK;
    dec_push   = 1'b0;
    dec_pop    = 1'b0;
    dec_move   = 1'b0;
    dec_up     = 1'b0;
    dec_ptr    = '0;
    dec_stop   = '0;
    inc_mask   = '0;
    dec_mask   = '0;
    if (!s_valid) begin
      unique case (item_action)
        ACT_PUSH:     dec_status = ST_FULL;
        ACT_POP:      dec_status = ST_EMPTY;
        ACT_SHIFT_UP: dec_status = ST_NO_SHIFT;
        ACT_SHIFT_DN: dec_status = ST_NO_SHIFT;
      endcase
    end else begin
      unique case (item_action)
        ACT_PUSH: begin
          if (full_s) begin
            dec_status = ST_FULL;
          end else begin
            dec_push = 1'b1;
          end
        end
        ACT_POP: begin
          if (fill_s <= start_s) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_pop = 1'b1;
          end
        end
        ACT_SHIFT_UP: begin
          if (!full_s || s_last) begin
            dec_status = ST_NO_SHIFT;
          end else if (!jr_found) begin
            dec_status = ST_NO_SPACE;
          end else begin
            // Words from the next region's base to the top of stack jr move up one.
            dec_move = 1'b1;
            dec_up   = 1'b1;
            dec_ptr  = fill_point[jr];
            dec_stop = limit_s;
            for (int k = 0; k < STACKS; k++) begin
              inc_mask[k] = (SW'(k) > s_sel) && (SW'(k) <= jr);
            end
          end
        end
        ACT_SHIFT_DN: begin
          if (!full_s || (s_sel == '0)) begin
            dec_status = ST_NO_SHIFT;
          end else if (!jl_found) begin
            dec_status = ST_NO_SPACE;
          end else begin
            // Words from the base above stack jl to the top of this stack move down one.
            dec_move = 1'b1;
            dec_up   = 1'b0;
            dec_ptr  = limit[jl];
            dec_stop = fill_s;
            for (int k = 0; k < STACKS; k++) begin
              dec_mask[k] = (SW'(k) > jl) && (SW'(k) <= s_sel);
            end
          end
        end
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !res_pending;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign ptr_step      = move_up ? AW'(ptr - 1'b1) : AW'(ptr + 1'b1);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_EXEC: begin
        if (dec_push) begin
          mem_we    = 1'b1;
          mem_waddr = fill_s[MW-1:0];
          mem_wdata = item_value;
        end
        if (dec_pop) begin
          mem_re    = 1'b1;
          mem_raddr = fill_s[MW-1:0] - 1'b1;
        end
      end
      S_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = move_up ? ptr_step[MW-1:0] : ptr[MW-1:0];
      end
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = move_up ? ptr[MW-1:0] : (ptr[MW-1:0] - 1'b1);
      end
      S_IDLE, S_POP_RD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Output register load: a finished result goes out as soon as the slot is free.
  always_comb begin
    out_load   = 1'b0;
    out_value  = '0;
    out_status = res_status;
    if (out_free) begin
      if (state == S_EXEC && !dec_pop && !dec_move) begin
        out_load   = 1'b1;
        out_status = dec_status;
      end else if (state == S_POP_RD) begin
        out_load   = 1'b1;
        out_value  = mem_rdata;
        out_status = ST_OK;
      end else if (state == S_IDLE && res_pending) begin
        out_load   = 1'b1;
        out_status = res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_value;
      m_axis_tuser <= out_status;
    end
  end

  // Sequencer. A pop result that cannot leave at once waits in S_POP_RD;
  // other results wait as res_pending with the block back in idle but not ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_pending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (res_pending) begin
            if (out_load) begin
              res_pending <= 1'b0;
            end
          end else if (s_axis_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (dec_pop) begin
            state <= S_POP_RD;
          end else if (dec_move && (dec_ptr != dec_stop)) begin
            state <= S_MOVE_RD;
          end else begin
            state       <= S_IDLE;
            res_pending <= !out_load;
          end
        end
        S_POP_RD: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        S_MOVE_RD: begin
          state <= S_MOVE_WR;
        end
        S_MOVE_WR: begin
          if (ptr_step == stop) begin
            state       <= S_IDLE;
            res_pending <= 1'b1;
          end else begin
            state <= S_MOVE_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Transaction capture, move cursor and held status.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && !res_pending && s_axis_tvalid) begin
      item_action <= action_t'(s_axis_tuser[1:0]);
      item_stack  <= s_axis_tuser[3:2];
      item_value  <= s_axis_tdata;
    end
    if (state == S_EXEC) begin
      ptr        <= dec_ptr;
      stop       <= dec_stop;
      move_up    <= dec_up;
      res_status <= dec_status;
    end else if (state == S_MOVE_WR) begin
      ptr <= ptr_step;
    end
  end

  // Region bounds and fill pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STACKS; k++) begin
        region_start[k] <= AW'((k * DEPTH) / STACKS);
        fill_point[k]   <= AW'((k * DEPTH) / STACKS);
      end
    end else if (state == S_EXEC) begin
      if (dec_push) begin
        fill_point[s_sel] <= AW'(fill_s + 1'b1);
      end
      if (dec_pop) begin
        fill_point[s_sel] <= AW'(fill_s - 1'b1);
      end
      for (int k = 0; k < STACKS; k++) begin
        if (inc_mask[k]) begin
          region_start[k] <= AW'(region_start[k] + 1'b1);
          fill_point[k]   <= AW'(fill_point[k] + 1'b1);
        end else if (dec_mask[k]) begin
          region_start[k] <= AW'(region_start[k] - 1'b1);
          fill_point[k]   <= AW'(fill_point[k] - 1'b1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pms_checker.sv */
// Port-level checks for the partitioned multi-stack, attached to the top level by bind.
// Depends on pms_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module pms_checker
  import pms_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= ST_NO_SPACE))
    else $error("undefined status code");

  // A result with a failing status carries a zero word.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero word with failing status");

  // One transaction at a time: no acceptance right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind partitioned_multi_stack pms_checker u_pms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
